// ===== rtl/pls_pkg.sv =====
`timescale 1ns / 1ps

package pls_pkg;

    // Default number of records the store can hold.
    localparam int CAPACITY_DEF = 64;

    // Operation codes carried in the request.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    // Status codes carried in the response.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One stored record.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         kind;
    } t_rec;

    // Request payload.
    typedef struct packed {
        logic [1:0]         operation;
        logic signed [7:0]  position;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic [7:0]         kind;
    } t_in;

    // Response payload.
    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         position_used;
        logic signed [15:0] read_x;
        logic signed [15:0] read_y;
        logic [7:0]         read_kind;
        logic [6:0]         count;
    } t_out;

    // Shift commands broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ===== rtl/pls_cell.sv =====
`timescale 1ns / 1ps

module pls_cell import pls_pkg::*; #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [IW-1:0] i_wr_at,
    input  logic [IW-1:0] i_rd_at,
    input  t_rec          i_new,
    input  t_rec          i_left,
    input  t_rec          i_right,
    input  t_rec          i_rd_in,
    output t_rec          o_rec,
    output t_rec          o_rd
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    t_rec r_rec;
    t_rec r_rd;
    t_rec n_rec;

    // Cells above the insert point take their lower neighbour, the cell at it takes the new record;
    // cells at or above the removal point take their upper neighbour.
    always_comb begin
        n_rec = r_rec;
        if (i_ctl.ins) begin
            if (MY_IDX > i_wr_at) begin
                n_rec = i_left;
            end else if (MY_IDX == i_wr_at) begin
                n_rec = i_new;
            end
        end else if (i_ctl.rem) begin
            if (MY_IDX >= i_wr_at) begin
                n_rec = i_right;
            end
        end
    end

    // Record storage and the read chain stage: the addressed cell drops its
    // record into the chain, every other cell passes its neighbour's value on.
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
        r_rd  <= (MY_IDX == i_rd_at) ? r_rec : i_rd_in;
    end

    assign o_rec = r_rec;
    assign o_rd  = r_rd;

endmodule

// ===== rtl/positional_list_store.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// request   in         i_in_valid / o_in_stall       i_in_data  (t_in)
// response  out        o_out_valid / i_out_stall     o_out_data (t_out)
//
// Insert, remove and failed operations answer in the cycle after the transfer,
// the whole row of cells shifting at once. A read walks the read chain one
// cell per cycle and answers at the end of the walk.
// Requests stall during a read and while a response waits under stall.
// Reset is synchronous and active low; it clears the record count and the
// control state, record contents are left as they are.

module positional_list_store import pls_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 8) ? CW : 8) + 1;
    localparam logic signed [PW-1:0] MINUS_ONE = '1;
    localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);
    localparam logic [IW-1:0] CYC_LAST = IW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_rd_at, n_rd_at;
    logic [IW-1:0] r_cyc, n_cyc;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    logic              in_acc;
    logic              out_free;
    logic signed [PW-1:0] pos_ext;
    logic signed [PW-1:0] cnt_ext;
    logic              pos_ins_ok;
    logic              pos_idx_ok;
    logic              full;
    logic [IW-1:0]     wr_at;
    t_cell_ctl         ctl;
    t_rec              new_rec;

    t_rec w_rec [CAPACITY];
    t_rec w_rd  [CAPACITY];

    // Handshake: the response register is free when empty or being taken.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Position checks against the current count.
    assign pos_ext    = PW'(i_in_data.position);
    assign cnt_ext    = signed'(PW'(r_count));
    assign pos_ins_ok = (pos_ext >= MINUS_ONE) && (pos_ext <= cnt_ext);
    assign pos_idx_ok = (pos_ext >= signed'(PW'(0))) && (pos_ext < cnt_ext);
    assign full       = (r_count == CNT_FULL);
    assign wr_at      = (pos_ext == MINUS_ONE) ? IW'(r_count) : IW'(pos_ext);

    assign new_rec.x    = i_in_data.coord_x;
    assign new_rec.y    = i_in_data.coord_y;
    assign new_rec.kind = i_in_data.kind;

    assign ctl.ins = in_acc && (i_in_data.operation == OP_INSERT) && pos_ins_ok && !full;
    assign ctl.rem = in_acc && (i_in_data.operation == OP_REMOVE) && pos_idx_ok;

    // Sequencer, count and response register.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_at     = r_rd_at;
        n_cyc       = r_cyc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out.status        = ST_RANGE;
                    n_out.position_used = '0;
                    n_out.read_x        = '0;
                    n_out.read_y        = '0;
                    n_out.read_kind     = '0;
                    n_out_valid         = 1'b1;
                    if (ctl.ins) begin
                        n_count             = r_count + CW'(1);
                        n_out.status        = ST_OK;
                        n_out.position_used = 6'(wr_at);
                    end else if (ctl.rem) begin
                        n_count             = r_count - CW'(1);
                        n_out.status        = ST_OK;
                        n_out.position_used = 6'(wr_at);
                    end else if ((i_in_data.operation == OP_INSERT) && pos_ins_ok) begin
                        n_out.status = ST_FULL;
                    end else if ((i_in_data.operation == OP_READ) && pos_idx_ok) begin
                        n_out_valid = r_out_valid && i_out_stall;
                        n_rd_at     = IW'(pos_ext);
                        n_cyc       = '0;
                        n_state     = S_READ;
                    end
                    n_out.count = 7'(n_count);
                end
            end
            S_READ: begin
                n_cyc = r_cyc + IW'(1);
                if (r_cyc == CYC_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out.status        = ST_OK;
                    n_out.position_used = 6'(r_rd_at);
                    n_out.read_x        = w_rd[CAPACITY-1].x;
                    n_out.read_y        = w_rd[CAPACITY-1].y;
                    n_out.read_kind     = w_rd[CAPACITY-1].kind;
                    n_out.count         = 7'(r_count);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cyc       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_cyc       <= n_cyc;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_at <= n_rd_at;
        r_out   <= n_out;
    end

    // The row of record cells with its read chain.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_rec left_rec, right_rec, rd_in;
        if (g == 0) begin : g_first
            assign left_rec = '0;
            assign rd_in    = '0;
        end else begin : g_mid
            assign left_rec = w_rec[g-1];
            assign rd_in    = w_rd[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_rec = '0;
        end else begin : g_inner
            assign right_rec = w_rec[g+1];
        end
        pls_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_wr_at (wr_at),
            .i_rd_at (r_rd_at),
            .i_new   (new_rec),
            .i_left  (left_rec),
            .i_right (right_rec),
            .i_rd_in (rd_in),
            .o_rec   (w_rec[g]),
            .o_rd    (w_rd[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("record count above capacity");

    // The count moves by at most one per cycle.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1))
                 || (r_count == $past(r_count) - CW'(1)))
        else $error("record count jumped");

    // The store is left alone while a read walks the chain.
    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !ctl.ins && !ctl.rem)
        else $error("store shifted during a read");

    // Only a successful read carries record fields.
    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_OK)) |->
            (r_out.read_x == '0) && (r_out.read_y == '0) && (r_out.read_kind == '0))
        else $error("record fields on a failed operation");

endmodule
